// ===== rtl/tht_pkg.sv =====
// Shared types and constants of the timed handler table.
`default_nettype none
package tht_pkg;
    localparam int NumEntries = 16;
    localparam int IdxW = $clog2(NumEntries);
    localparam int CntW = $clog2(NumEntries + 1);
    localparam int ResultCap = 16;
    localparam int NCapW = $clog2(ResultCap + 1);

    localparam logic [1:0] CMD_TICK    = 2'd0;
    localparam logic [1:0] CMD_SCHED   = 2'd1;
    localparam logic [1:0] CMD_STOP    = 2'd2;
    localparam logic [1:0] CMD_UNKNOWN = 2'd3;

    localparam logic [2:0] KIND_FIRE  = 3'd0;
    localparam logic [2:0] KIND_NONE  = 3'd1;
    localparam logic [2:0] KIND_SCHED = 3'd2;
    localparam logic [2:0] KIND_FULL  = 3'd3;
    localparam logic [2:0] KIND_STOP  = 3'd4;

    // command handed from front to back part
    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] now_time;
        logic [31:0] start_delay;
        logic [31:0] repeat_period;
        logic [15:0] tick_budget;
        logic [15:0] group_tag;
    } t_cmd;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] fired_tag;
        logic [15:0] handler_id;
        logic [31:0] frame_delta;
        logic [4:0]  removed_count;
        logic        last;
    } t_res;
endpackage
`default_nettype wire

// ===== rtl/tht_front.sv =====
// Front part: accept items, drop unknown commands, two-entry queue to the back part.
`default_nettype none
module tht_front import tht_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire t_cmd        i_cmd,
    output logic             o_q_valid,
    input  wire logic        i_q_pop,
    output t_cmd             o_q_cmd
);
    t_cmd r_q [2];
    logic r_rd, r_wr;
    logic [1:0] r_cnt;
    logic push;

    assign o_stall   = (r_cnt == 2'd2);
    // unknown commands are accepted and dropped here
    assign push      = i_valid && !o_stall && (i_cmd.cmd != CMD_UNKNOWN);
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_cmd   = r_q[r_rd];

    // advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd <= 1'b0;
            r_wr <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wr <= ~r_wr;
            if (i_q_pop) r_rd <= ~r_rd;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, i_q_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wr] <= i_cmd;
    end
endmodule
`default_nettype wire

// ===== rtl/tht_back.sv =====
// Back part: entry table and sequencer that walks entries one per cycle; a tick walk holds while the output is stalled.
`default_nettype none
module tht_back import tht_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_q_valid,
    output logic       o_q_pop,
    input  wire t_cmd  i_q_cmd,
    output logic       o_valid,
    input  wire logic  i_stall,
    output t_res       o_res,
    output logic       o_busy
);
    typedef enum logic [1:0] {S_IDLE, S_TICK, S_STOP, S_OUT} t_state;

    t_state r_state;
    t_cmd   r_cmd;
    logic [31:0] r_prev;
    logic        r_first;
    logic [CntW-1:0] r_count;
    logic [15:0] r_next_id;
    logic [31:0] r_delta;
    logic [IdxW-1:0] r_rd;   // read index
    logic [CntW-1:0] r_i;    // entries walked
    logic [CntW-1:0] r_wr;   // compacted write index
    logic [NCapW-1:0] r_n;
    logic [4:0] r_removed;
    logic        r_valid;
    t_res        r_res;
    t_res        r_hold;     // newest fire result, sent once the next one is known

    logic [31:0] e_delay [NumEntries];
    logic [31:0] e_period[NumEntries];
    logic [15:0] e_budget[NumEntries];
    logic [15:0] e_tag   [NumEntries];
    logic [15:0] e_id    [NumEntries];
    logic [31:0] e_last  [NumEntries];

    logic [31:0] el, cur_delay, cur_last;
    logic [15:0] cur_budget;
    logic run, keep, out_free, walk_done, emit;
    logic [31:0] tick_delta, tick_prev;

    assign out_free  = !r_valid || !i_stall;
    assign o_valid   = r_valid;
    assign o_res     = r_res;
    assign o_busy    = (r_state != S_IDLE);
    assign walk_done = (r_i == r_count);
    assign o_q_pop   = (r_state == S_IDLE) && i_q_valid && out_free;

    // a result item is loaded into the output register this cycle
    assign emit = ((r_state == S_IDLE) && o_q_pop && (i_q_cmd.cmd == CMD_SCHED))
        || ((r_state == S_TICK) && out_free && (walk_done ? (r_n == '0)
            : (run && (r_n != '0) && (r_n < NCapW'(ResultCap)))))
        || ((r_state == S_OUT) && out_free)
        || ((r_state == S_STOP) && walk_done && out_free);

    // evaluate the entry under the read index
    always_comb begin
        el  = r_cmd.now_time - e_last[r_rd];
        run = 1'b1;
        cur_delay = e_delay[r_rd];
        if (e_delay[r_rd] != 32'd0) begin
            if (el >= e_delay[r_rd]) cur_delay = 32'd0;
            else run = 1'b0;
        end
        if (e_period[r_rd] != 32'd0 && el < e_period[r_rd]) run = 1'b0;
        cur_last   = run ? r_cmd.now_time : e_last[r_rd];
        cur_budget = e_budget[r_rd];
        keep = 1'b1;
        if (cur_budget != 16'd0) begin
            cur_budget = cur_budget - 16'd1;
            if (cur_budget == 16'd0) keep = 1'b0;
        end
        tick_prev  = r_first ? i_q_cmd.now_time : r_prev;
        tick_delta = i_q_cmd.now_time - tick_prev;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_prev <= 32'd0;
            r_first <= 1'b1;
            r_count <= '0;
            r_next_id <= 16'd0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= emit || (r_valid && i_stall);
            case (r_state)
                S_IDLE: begin
                    if (o_q_pop) begin
                        r_cmd <= i_q_cmd;
                        r_rd <= '0;
                        r_i <= '0;
                        r_wr <= '0;
                        r_n <= '0;
                        r_removed <= 5'd0;
                        case (i_q_cmd.cmd)
                            CMD_TICK: begin
                                r_first <= 1'b0;
                                r_prev <= i_q_cmd.now_time;
                                r_delta <= tick_delta;
                                r_state <= S_TICK;
                            end
                            CMD_SCHED: begin
                                r_res.fired_tag <= i_q_cmd.group_tag;
                                r_res.frame_delta <= 32'd0;
                                r_res.removed_count <= 5'd0;
                                r_res.last <= 1'b1;
                                if (r_count >= CntW'(NumEntries)) begin
                                    r_res.kind <= KIND_FULL;
                                    r_res.handler_id <= 16'd0;
                                end else begin
                                    r_res.kind <= KIND_SCHED;
                                    r_res.handler_id <= r_next_id;
                                    e_delay [r_count[IdxW-1:0]] <= i_q_cmd.start_delay;
                                    e_period[r_count[IdxW-1:0]] <= i_q_cmd.repeat_period;
                                    e_budget[r_count[IdxW-1:0]] <= i_q_cmd.tick_budget;
                                    e_tag   [r_count[IdxW-1:0]] <= i_q_cmd.group_tag;
                                    e_id    [r_count[IdxW-1:0]] <= r_next_id;
                                    e_last  [r_count[IdxW-1:0]] <= i_q_cmd.now_time;
                                    r_count <= r_count + 1'b1;
                                    r_next_id <= r_next_id + 16'd1;
                                end
                            end
                            default: r_state <= S_STOP;
                        endcase
                    end
                end
                S_TICK: begin
                    if (walk_done) begin
                        if (r_n == '0) begin
                            if (out_free) begin
                                r_count <= r_wr;
                                r_res <= '{KIND_NONE, 16'd0, 16'd0, r_delta, 5'd0, 1'b1};
                                r_state <= S_IDLE;
                            end
                        end else begin
                            r_count <= r_wr;
                            r_state <= S_OUT;
                        end
                    end else if (out_free) begin
                        // compact survivors downward
                        if (keep) begin
                            e_delay [r_wr[IdxW-1:0]] <= cur_delay;
                            e_period[r_wr[IdxW-1:0]] <= e_period[r_rd];
                            e_budget[r_wr[IdxW-1:0]] <= cur_budget;
                            e_tag   [r_wr[IdxW-1:0]] <= e_tag[r_rd];
                            e_id    [r_wr[IdxW-1:0]] <= e_id[r_rd];
                            e_last  [r_wr[IdxW-1:0]] <= cur_last;
                            r_wr <= r_wr + 1'b1;
                        end
                        if (run && r_n < NCapW'(ResultCap)) begin
                            // send the held fire, hold the new one; S_OUT closes the tick
                            if (r_n != '0) r_res <= r_hold;
                            r_hold <= '{KIND_FIRE, e_tag[r_rd], e_id[r_rd], r_delta,
                                        5'd0, 1'b0};
                            r_n <= r_n + 1'b1;
                        end
                        r_rd <= r_rd + 1'b1;
                        r_i <= r_i + 1'b1;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_res <= '{r_hold.kind, r_hold.fired_tag, r_hold.handler_id,
                                   r_hold.frame_delta, r_hold.removed_count, 1'b1};
                        r_state <= S_IDLE;
                    end
                end
                S_STOP: begin
                    if (walk_done) begin
                        if (out_free) begin
                            r_count <= r_wr;
                            r_res <= '{KIND_STOP, r_cmd.group_tag, 16'd0, 32'd0,
                                       r_removed, 1'b1};
                            r_state <= S_IDLE;
                        end
                    end else begin
                        if (e_tag[r_rd] == r_cmd.group_tag) begin
                            r_removed <= r_removed + 5'd1;
                        end else begin
                            e_delay [r_wr[IdxW-1:0]] <= e_delay[r_rd];
                            e_period[r_wr[IdxW-1:0]] <= e_period[r_rd];
                            e_budget[r_wr[IdxW-1:0]] <= e_budget[r_rd];
                            e_tag   [r_wr[IdxW-1:0]] <= e_tag[r_rd];
                            e_id    [r_wr[IdxW-1:0]] <= e_id[r_rd];
                            e_last  [r_wr[IdxW-1:0]] <= e_last[r_rd];
                            r_wr <= r_wr + 1'b1;
                        end
                        r_rd <= r_rd + 1'b1;
                        r_i <= r_i + 1'b1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== rtl/timed_handler_table_unit.sv =====
// A schedule answers from the idle state; tick and stop walk every table entry, and a tick that fired closes in S_OUT.
// The back part takes a new item only once it is idle again; it walks one table entry per cycle
// through a single compaction port, and a tick walk holds while the output is stalled.
// A two-entry queue lets the front accept items while the back is busy.
// Reset (synchronous, active low) empties table and queue and arms the first tick.
`default_nettype none
module timed_handler_table_unit import tht_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_cmd,
    input  wire logic [31:0] i_now_time,
    input  wire logic [31:0] i_start_delay,
    input  wire logic [31:0] i_repeat_period,
    input  wire logic [15:0] i_tick_budget,
    input  wire logic [15:0] i_group_tag,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [2:0]       o_kind,
    output logic [15:0]      o_fired_tag,
    output logic [15:0]      o_handler_id,
    output logic [31:0]      o_frame_delta,
    output logic [4:0]       o_removed_count,
    output logic             o_last
);
    t_cmd in_cmd, q_cmd;
    t_res res;
    logic q_valid, q_pop, busy;

    assign in_cmd = '{i_cmd, i_now_time, i_start_delay, i_repeat_period,
                      i_tick_budget, i_group_tag};

    tht_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_cmd(in_cmd),
        .o_q_valid(q_valid), .i_q_pop(q_pop), .o_q_cmd(q_cmd)
    );

    tht_back u_back (
        .i_clk, .i_rst_n, .i_q_valid(q_valid), .o_q_pop(q_pop), .i_q_cmd(q_cmd),
        .o_valid, .i_stall, .o_res(res), .o_busy(busy)
    );

    assign o_kind          = res.kind;
    assign o_fired_tag     = res.fired_tag;
    assign o_handler_id    = res.handler_id;
    assign o_frame_delta   = res.frame_delta;
    assign o_removed_count = res.removed_count;
    assign o_last          = res.last;

`ifndef NO_ASSERTIONS
    // queue is only popped while the sequencer is idle
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !busy) else $error("pop while busy");
    // a stalled result holds its value
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(res)) else $error("result dropped");
    // pop needs a queued command
    a_pop_q: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid) else $error("pop of empty queue");
`endif
endmodule
`default_nettype wire
